// File: sv/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: sv/dme_pkg.sv
package dme_pkg;

   localparam logic [2:0] TAG_Y_HERE = 3'd1;
   localparam logic [2:0] TAG_Z_HERE = 3'd2;
   localparam logic [2:0] TAG_YZ_OK  = 3'd3;
   localparam logic [2:0] TAG_Y_OK   = 3'd4;
   localparam logic [2:0] TAG_Z_OK   = 3'd5;
   localparam logic [2:0] TAG_FIXED  = 3'd6;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_Y    = 2'd1;
   localparam logic [1:0] SEEN_Z    = 2'd2;

   localparam logic [7:0] OP_DOWN1  = 8'd157;
   localparam logic [7:0] OP_RIGHT1 = 8'd143;

   localparam logic [1:0] KIND_EMIT    = 2'd0;
   localparam logic [1:0] KIND_PATCH_Y = 2'd1;
   localparam logic [1:0] KIND_PATCH_Z = 2'd2;

   localparam logic OPER_MOVE  = 1'b0;
   localparam logic OPER_PRUNE = 1'b1;

   // magnitude thresholds for 4, 3 and 2 operand bytes
   localparam logic [31:0] LEN4_MIN = 32'o40000000;
   localparam logic [31:0] LEN3_MIN = 32'o100000;
   localparam logic [31:0] LEN2_MIN = 32'o200;

endpackage

// File: sv/dvi_movement_encoder.sv
// Movement encoder with register reuse for a page byte stream.
// req channel: one beat per item. tuser[0] = 1 prunes both history stacks
// back to the bound in position; tuser[0] = 0 encodes a move on the axis in
// tuser[1]. rsp channel: one beat per result, tuser gives the kind (emit
// byte or patch an earlier opcode), tlast marks the final beat of an item.
// A prune gives no beats.
// Timing: the history walk reads one entry per cycle from a shared RAM port.
// A move runs through accept, a walk over the stack entries (one read more
// when the walk runs past the fill), a tag rewrite of the entries newer than
// a register hit, a push and 1 to 5 result beats. A prune walks over the
// dropped entries of each axis in turn. req_tready is high only while no
// item is in work.
// The result register lets the next item start while the last beat waits;
// a stalled receiver holds the sequencer in its emit phase.
// Reset empties both stacks (counts and heads to zero); no clearing pass
// runs, stack entries are read only below the fill count.
module dvi_movement_encoder #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] amount, [62:32] position, [93:63] flushed_bytes, [95:94] zero
   input  logic [95:0] req_tdata,
   // [0] operation, [1] axis
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_value, [38:8] patch_position, [39] zero
   output logic [39:0] rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int PW = $clog2(HISTORY_DEPTH);
   localparam int IW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW = IW + 1;
   localparam int EW = 66;
   localparam logic [IW-1:0] DEPTH_I = IW'(HISTORY_DEPTH);

   typedef enum logic [2:0] {S_IDLE, S_WALK, S_TAGS, S_PRUNE, S_PUSH, S_EMIT} state_type;

   state_type      state_ff, state_in;
   logic           axis_ff, axis_in;
   logic [31:0]    amt_ff, amt_in;
   logic [30:0]    pos_ff, pos_in;
   logic [30:0]    gone_ff, gone_in;
   logic [PW-1:0]  head_ff [2];
   logic [PW-1:0]  head_in [2];
   logic [IW-1:0]  count_ff [2];
   logic [IW-1:0]  count_in [2];
   logic [1:0]     seen_ff, seen_in;
   logic           prime_ff, prime_in;
   logic [IW-1:0]  rd_idx_ff, rd_idx_in;
   logic [IW-1:0]  ev_idx_ff, ev_idx_in;
   logic           hit_ff, hit_in;
   logic [1:0]     kind_ff, kind_in;
   logic [IW-1:0]  hit_idx_ff, hit_idx_in;
   logic [30:0]    hit_pos_ff, hit_pos_in;
   logic [2:0]     new_tag_ff, new_tag_in;
   logic [2:0]     len_ff, len_in;
   logic [2:0]     res_idx_ff, res_idx_in;
   logic [2:0]     res_cnt_ff, res_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic [30:0]    rsp_pos_ff, rsp_pos_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           wr_en;
   logic [PW:0]    wr_addr;
   logic [EW-1:0]  wr_data;
   logic [PW:0]    rd_addr;
   logic [EW-1:0]  rd_data;

   function automatic logic [PW-1:0] wrap(input logic [PW-1:0] h, input logic [IW-1:0] i);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(i);
      if (s >= SW'(HISTORY_DEPTH)) begin
         s = s - SW'(HISTORY_DEPTH);
      end
      return s[PW-1:0];
   endfunction

   logic [IW-1:0] n;
   logic [31:0]   ent_amt;
   logic [30:0]   ent_pos;
   logic [2:0]    ent_tag;
   logic [PW-1:0] ev_phys;
   logic [PW-1:0] new_head;
   logic [31:0]   mag;
   logic [7:0]    base;
   logic [1:0]    byte_sel;
   logic          ytake, ztake, reuse;

   assign n       = count_ff[axis_ff];
   assign ent_amt = rd_data[31:0];
   assign ent_pos = rd_data[62:32];
   assign ent_tag = rd_data[65:63];
   assign ev_phys = wrap(head_ff[axis_ff], ev_idx_ff);
   assign new_head = (head_ff[axis_ff] == '0) ? PW'(HISTORY_DEPTH - 1)
                                              : head_ff[axis_ff] - PW'(1);
   assign rd_addr = {axis_ff, wrap(head_ff[axis_ff], rd_idx_ff)};
   assign mag     = amt_ff[31] ? (32'd0 - amt_ff) : amt_ff;
   assign base    = axis_ff ? dme_pkg::OP_RIGHT1 : dme_pkg::OP_DOWN1;
   assign byte_sel = 2'(len_ff - res_idx_ff);

   assign ytake = (ent_tag == dme_pkg::TAG_YZ_OK || ent_tag == dme_pkg::TAG_Y_OK)
                  && seen_ff != dme_pkg::SEEN_Y;
   assign ztake = (seen_ff == dme_pkg::SEEN_NONE && ent_tag == dme_pkg::TAG_Z_OK) ||
                  (seen_ff == dme_pkg::SEEN_Y &&
                   (ent_tag == dme_pkg::TAG_YZ_OK || ent_tag == dme_pkg::TAG_Z_OK));
   assign reuse = (seen_ff == dme_pkg::SEEN_NONE &&
                   (ent_tag == dme_pkg::TAG_Y_HERE || ent_tag == dme_pkg::TAG_Z_HERE)) ||
                  (seen_ff == dme_pkg::SEEN_Y && ent_tag == dme_pkg::TAG_Z_HERE) ||
                  (seen_ff == dme_pkg::SEEN_Z && ent_tag == dme_pkg::TAG_Y_HERE);

   always_comb begin
      logic [2:0] tg;
      state_in    = state_ff;
      axis_in     = axis_ff;
      amt_in      = amt_ff;
      pos_in      = pos_ff;
      gone_in     = gone_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      seen_in     = seen_ff;
      prime_in    = 1'b0;
      rd_idx_in   = (rd_idx_ff == DEPTH_I) ? DEPTH_I : rd_idx_ff + IW'(1);
      ev_idx_in   = rd_idx_ff;
      hit_in      = hit_ff;
      kind_in     = kind_ff;
      hit_idx_in  = hit_idx_ff;
      hit_pos_in  = hit_pos_ff;
      new_tag_in  = new_tag_ff;
      len_in      = len_ff;
      res_idx_in  = res_idx_ff;
      res_cnt_in  = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in = rsp_byte_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      wr_en       = 1'b0;
      wr_addr     = {axis_ff, ev_phys};
      wr_data     = rd_data;
      tg          = ent_tag;

      case (state_ff)
         S_IDLE: begin
            rd_idx_in = '0;
            prime_in  = 1'b1;
            if (req_tvalid) begin
               amt_in     = req_tdata[31:0];
               pos_in     = req_tdata[62:32];
               gone_in    = req_tdata[93:63];
               seen_in    = dme_pkg::SEEN_NONE;
               hit_in     = 1'b0;
               kind_in    = dme_pkg::KIND_EMIT;
               new_tag_in = dme_pkg::TAG_YZ_OK;
               if (req_tuser[0] == dme_pkg::OPER_PRUNE) begin
                  axis_in  = 1'b0;
                  state_in = S_PRUNE;
               end else begin
                  axis_in  = req_tuser[1];
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (!prime_ff) begin
               if (ev_idx_ff >= n) begin
                  state_in = S_PUSH;
               end else if (ent_amt == amt_ff) begin
                  if (ytake || ztake) begin
                     if (ent_pos < gone_ff) begin
                        state_in = S_PUSH;
                     end else begin
                        tg         = ytake ? dme_pkg::TAG_Y_HERE : dme_pkg::TAG_Z_HERE;
                        kind_in    = ytake ? dme_pkg::KIND_PATCH_Y : dme_pkg::KIND_PATCH_Z;
                        wr_en      = 1'b1;
                        wr_data    = {tg, ent_pos, ent_amt};
                        hit_in     = 1'b1;
                        hit_idx_in = ev_idx_ff;
                        hit_pos_in = ent_pos;
                        new_tag_in = tg;
                     end
                  end else if (reuse) begin
                     hit_in     = 1'b1;
                     hit_idx_in = ev_idx_ff;
                     hit_pos_in = ent_pos;
                     new_tag_in = ent_tag;
                  end
                  if (((ytake || ztake) && ent_pos >= gone_ff) ||
                      (!(ytake || ztake) && reuse)) begin
                     state_in  = (ev_idx_ff == '0) ? S_PUSH : S_TAGS;
                     rd_idx_in = '0;
                     prime_in  = 1'b1;
                  end
               end else begin
                  if (seen_ff == dme_pkg::SEEN_NONE && ent_tag == dme_pkg::TAG_Y_HERE) begin
                     seen_in = dme_pkg::SEEN_Y;
                  end else if (seen_ff == dme_pkg::SEEN_NONE &&
                               ent_tag == dme_pkg::TAG_Z_HERE) begin
                     seen_in = dme_pkg::SEEN_Z;
                  end else if ((seen_ff == dme_pkg::SEEN_Y &&
                                ent_tag == dme_pkg::TAG_Z_HERE) ||
                               (seen_ff == dme_pkg::SEEN_Z &&
                                ent_tag == dme_pkg::TAG_Y_HERE)) begin
                     state_in = S_PUSH;
                  end
               end
            end
         end
         S_TAGS: begin
            if (!prime_ff) begin
               if (ev_idx_ff < hit_idx_ff) begin
                  if (new_tag_ff == dme_pkg::TAG_Y_HERE) begin
                     if (ent_tag == dme_pkg::TAG_YZ_OK) tg = dme_pkg::TAG_Z_OK;
                     else if (ent_tag == dme_pkg::TAG_Y_OK) tg = dme_pkg::TAG_FIXED;
                  end else begin
                     if (ent_tag == dme_pkg::TAG_YZ_OK) tg = dme_pkg::TAG_Y_OK;
                     else if (ent_tag == dme_pkg::TAG_Z_OK) tg = dme_pkg::TAG_FIXED;
                  end
                  wr_en   = 1'b1;
                  wr_data = {tg, ent_pos, ent_amt};
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_PRUNE: begin
            if (!prime_ff) begin
               if (!(ev_idx_ff < n && ent_pos >= pos_ff)) begin
                  head_in[axis_ff]  = ev_phys;
                  count_in[axis_ff] = n - ev_idx_ff;
                  rd_idx_in = '0;
                  prime_in  = 1'b1;
                  if (axis_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     axis_in = 1'b1;
                  end
               end
            end
         end
         S_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = {axis_ff, new_head};
            wr_data = {new_tag_ff, pos_ff, amt_ff};
            head_in[axis_ff]  = new_head;
            count_in[axis_ff] = (n == DEPTH_I) ? DEPTH_I : n + IW'(1);
            if (mag >= dme_pkg::LEN4_MIN)      len_in = 3'd4;
            else if (mag >= dme_pkg::LEN3_MIN) len_in = 3'd3;
            else if (mag >= dme_pkg::LEN2_MIN) len_in = 3'd2;
            else                               len_in = 3'd1;
            if (hit_ff) begin
               res_cnt_in = (kind_ff != dme_pkg::KIND_EMIT) ? 3'd2 : 3'd1;
            end else begin
               res_cnt_in = len_in + 3'd1;
            end
            res_idx_in = '0;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = dme_pkg::KIND_EMIT;
               rsp_pos_in   = '0;
               if (hit_ff) begin
                  if (kind_ff != dme_pkg::KIND_EMIT && res_idx_ff == '0) begin
                     rsp_kind_in = kind_ff;
                     rsp_pos_in  = hit_pos_ff;
                     rsp_byte_in = '0;
                  end else begin
                     rsp_byte_in = base + ((new_tag_ff == dme_pkg::TAG_Y_HERE) ? 8'd4 : 8'd9);
                  end
               end else if (res_idx_ff == '0) begin
                  rsp_byte_in = base + 8'(len_ff) - 8'd1;
               end else begin
                  case (byte_sel)
                     2'd0:    rsp_byte_in = amt_ff[7:0];
                     2'd1:    rsp_byte_in = amt_ff[15:8];
                     2'd2:    rsp_byte_in = amt_ff[23:16];
                     default: rsp_byte_in = amt_ff[31:24];
                  endcase
               end
               rsp_last_in = (res_idx_ff == res_cnt_ff - 3'd1);
               res_idx_in  = res_idx_ff + 3'd1;
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         prime_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         prime_ff     <= prime_in;
      end
      axis_ff     <= axis_in;
      amt_ff      <= amt_in;
      pos_ff      <= pos_in;
      gone_ff     <= gone_in;
      seen_ff     <= seen_in;
      rd_idx_ff   <= rd_idx_in;
      ev_idx_ff   <= ev_idx_in;
      hit_ff      <= hit_in;
      kind_ff     <= kind_in;
      hit_idx_ff  <= hit_idx_in;
      hit_pos_ff  <= hit_pos_in;
      new_tag_ff  <= new_tag_in;
      len_ff      <= len_in;
      res_idx_ff  <= res_idx_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   dme_ram #(
      .WIDTH(EW),
      .DEPTH(2 ** (PW + 1))
   ) u_hist (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pos_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: sv/dme_ram.sv
module dme_ram #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dme_checker.sv
`include "assert_macros.svh"

module dme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [95:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // one item in work at a time
   `ASSERT_NEXT(a_busy_after_beat, clock, reset, req_beat, !req_tready)
   // hold a stalled result
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_tvalid, rsp_tuser <= dme_pkg::KIND_PATCH_Z)
   // a patch is always followed by its opcode
   `ASSERT_IMPLY(a_patch_not_last, clock, reset,
                 rsp_tvalid && rsp_tuser != dme_pkg::KIND_EMIT, !rsp_tlast)
   `ASSERT_IMPLY(a_emit_no_pos, clock, reset,
                 rsp_tvalid && rsp_tuser == dme_pkg::KIND_EMIT, rsp_tdata[38:8] == 31'd0)

endmodule

bind dvi_movement_encoder dme_checker u_dme_checker (.*);

// File: sim/dvi_movement_encoder_check.sv
module dvi_movement_encoder_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [30:0] patch_pos;
      logic        last;
   } beat_type;

   logic [31:0] hist_amount [2][DEPTH];
   logic [30:0] hist_pos    [2][DEPTH];
   logic [2:0]  hist_tag    [2][DEPTH];
   int          hist_count  [2];
   beat_type    expected_beats [$];

   assign pending = expected_beats.size();

   function automatic beat_type mk_beat(logic [1:0] k, logic [7:0] b, logic [30:0] p);
      beat_type r;
      r.kind = k;
      r.byte_value = b;
      r.patch_pos = p;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic prune_history(logic [30:0] bound);
      int d;
      for (int ax = 0; ax < 2; ax++) begin
         d = 0;
         while (d < hist_count[ax] && hist_pos[ax][d] >= bound) d++;
         for (int j = 0; j + d < hist_count[ax]; j++) begin
            hist_amount[ax][j] = hist_amount[ax][j+d];
            hist_pos[ax][j]    = hist_pos[ax][j+d];
            hist_tag[ax][j]    = hist_tag[ax][j+d];
         end
         hist_count[ax] -= d;
      end
   endtask

   task automatic encode_move(int ax, logic [31:0] w, logic [30:0] pos, logic [30:0] gone);
      int          n, hit;
      logic [1:0]  seen, kind;
      logic [2:0]  tg, newtag;
      logic [7:0]  base;
      logic [32:0] mag;
      int          len;
      bit          ytake, ztake, reuse;
      beat_type    outq [$];
      beat_type    b;
      n = hist_count[ax];
      seen = dme_pkg::SEEN_NONE;
      hit = -1;
      kind = dme_pkg::KIND_EMIT;
      newtag = dme_pkg::TAG_YZ_OK;
      base = ax ? dme_pkg::OP_RIGHT1 : dme_pkg::OP_DOWN1;
      for (int i = 0; i < n; i++) begin
         tg = hist_tag[ax][i];
         if (hist_amount[ax][i] == w) begin
            ytake = (tg == dme_pkg::TAG_YZ_OK || tg == dme_pkg::TAG_Y_OK) &&
                    seen != dme_pkg::SEEN_Y;
            ztake = (seen == dme_pkg::SEEN_NONE && tg == dme_pkg::TAG_Z_OK) ||
                    (seen == dme_pkg::SEEN_Y &&
                     (tg == dme_pkg::TAG_YZ_OK || tg == dme_pkg::TAG_Z_OK));
            reuse = (seen == dme_pkg::SEEN_NONE &&
                     (tg == dme_pkg::TAG_Y_HERE || tg == dme_pkg::TAG_Z_HERE)) ||
                    (seen == dme_pkg::SEEN_Y && tg == dme_pkg::TAG_Z_HERE) ||
                    (seen == dme_pkg::SEEN_Z && tg == dme_pkg::TAG_Y_HERE);
            if (ytake || ztake) begin
               if (hist_pos[ax][i] < gone) break;
               kind = ytake ? dme_pkg::KIND_PATCH_Y : dme_pkg::KIND_PATCH_Z;
               hist_tag[ax][i] = ytake ? dme_pkg::TAG_Y_HERE : dme_pkg::TAG_Z_HERE;
               hit = i;
               break;
            end
            if (reuse) begin
               hit = i;
               break;
            end
         end else begin
            if (seen == dme_pkg::SEEN_NONE && tg == dme_pkg::TAG_Y_HERE)
               seen = dme_pkg::SEEN_Y;
            else if (seen == dme_pkg::SEEN_NONE && tg == dme_pkg::TAG_Z_HERE)
               seen = dme_pkg::SEEN_Z;
            else if ((seen == dme_pkg::SEEN_Y && tg == dme_pkg::TAG_Z_HERE) ||
                     (seen == dme_pkg::SEEN_Z && tg == dme_pkg::TAG_Y_HERE)) break;
         end
      end
      if (hit >= 0) begin
         newtag = hist_tag[ax][hit];
         for (int j = 0; j < hit; j++) begin
            tg = hist_tag[ax][j];
            if (newtag == dme_pkg::TAG_Y_HERE) begin
               if (tg == dme_pkg::TAG_YZ_OK) hist_tag[ax][j] = dme_pkg::TAG_Z_OK;
               else if (tg == dme_pkg::TAG_Y_OK) hist_tag[ax][j] = dme_pkg::TAG_FIXED;
            end else begin
               if (tg == dme_pkg::TAG_YZ_OK) hist_tag[ax][j] = dme_pkg::TAG_Y_OK;
               else if (tg == dme_pkg::TAG_Z_OK) hist_tag[ax][j] = dme_pkg::TAG_FIXED;
            end
         end
         if (kind != dme_pkg::KIND_EMIT)
            outq.push_back(mk_beat(kind, 8'd0, hist_pos[ax][hit]));
         outq.push_back(mk_beat(dme_pkg::KIND_EMIT,
                                base + (newtag == dme_pkg::TAG_Y_HERE ? 8'd4 : 8'd9),
                                31'd0));
      end else begin
         mag = w[31] ? (33'h1_0000_0000 - {1'b0, w}) : {1'b0, w};
         len = mag >= dme_pkg::LEN4_MIN ? 4 : mag >= dme_pkg::LEN3_MIN ? 3 :
               mag >= dme_pkg::LEN2_MIN ? 2 : 1;
         outq.push_back(mk_beat(dme_pkg::KIND_EMIT, base + 8'(len - 1), 31'd0));
         for (int j = 0; j < len; j++)
            outq.push_back(mk_beat(dme_pkg::KIND_EMIT, 8'(w >> (8 * (len - 1 - j))), 31'd0));
      end
      // push the new entry, drop the oldest when full
      if (n == DEPTH) n--;
      for (int j = n; j > 0; j--) begin
         hist_amount[ax][j] = hist_amount[ax][j-1];
         hist_pos[ax][j]    = hist_pos[ax][j-1];
         hist_tag[ax][j]    = hist_tag[ax][j-1];
      end
      hist_amount[ax][0] = w;
      hist_pos[ax][0] = pos;
      hist_tag[ax][0] = newtag;
      hist_count[ax] = n + 1;
      outq[outq.size()-1].last = 1'b1;
      foreach (outq[k]) begin
         b = outq[k];
         expected_beats.push_back(b);
      end
   endtask

   initial begin
      errors = 0;
      hist_count[0] = 0;
      hist_count[1] = 0;
   end

   always @(posedge clock) begin
      beat_type want, got;
      if (reset) begin
         hist_count[0] = 0;
         hist_count[1] = 0;
         expected_beats.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == dme_pkg::OPER_PRUNE) prune_history(req_tdata[62:32]);
            else encode_move(int'(req_tuser[1]), req_tdata[31:0], req_tdata[62:32],
                             req_tdata[93:63]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[38:8], rsp_tlast};
            if (expected_beats.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat %h", $realtime, got);
            end else begin
               want = expected_beats.pop_front();
               if (got.kind != want.kind) begin
                  errors++;
                  $display("%0t: kind expected %0d actual %0d", $realtime, want.kind,
                           got.kind);
               end
               if (got.byte_value != want.byte_value) begin
                  errors++;
                  $display("%0t: byte expected %0d actual %0d", $realtime,
                           want.byte_value, got.byte_value);
               end
               if (got.patch_pos != want.patch_pos) begin
                  errors++;
                  $display("%0t: patch position expected %0d actual %0d", $realtime,
                           want.patch_pos, got.patch_pos);
               end
               if (got.last != want.last) begin
                  errors++;
                  $display("%0t: last expected %0d actual %0d", $realtime, want.last,
                           got.last);
               end
            end
         end
      end
   end

endmodule

// File: sim/dvi_movement_encoder_test.sv
module dvi_movement_encoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   int          errors, pending;
   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   bit          hold_off = 1'b0;
   logic [30:0] cur_pos = 31'd10;
   logic [31:0] amount_pool [8];
   int          cycles = 0;

   dvi_movement_encoder dut (.*);

   dvi_movement_encoder_check checker_i (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic send(logic op, logic ax, logic [31:0] amt, logic [30:0] pos,
                       logic [30:0] gone);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {ax, op};
      req_tdata <= {2'b00, gone, pos, amt};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
   endtask

   task automatic move(logic ax, logic [31:0] amt, int lag);
      cur_pos = cur_pos + 31'($urandom_range(1, 6));
      send(dme_pkg::OPER_MOVE, ax, amt, cur_pos,
           cur_pos > lag ? cur_pos - 31'(lag) : 31'd0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic random_item();
      int r;
      logic [31:0] amt;
      r = $urandom_range(99);
      case ($urandom_range(3))
         0: amt = $urandom;
         1: amt = 32'(int'($urandom_range(65535)) - 32768);
         default: amt = amount_pool[$urandom_range(7)];
      endcase
      if (r < 5)
         send(dme_pkg::OPER_PRUNE, 1'($urandom), $urandom,
              cur_pos - 31'($urandom_range(40)), 31'($urandom));
      else if (r < 12)
         send(dme_pkg::OPER_MOVE, 1'($urandom), $urandom, 31'($urandom), 31'($urandom));
      else
         move(1'($urandom), amt, $urandom_range(60));
   endtask

   initial begin
      foreach (amount_pool[k])
         amount_pool[k] = (k < 4) ? 32'($urandom_range(200)) : $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: length boundaries, reuse chains, unflushed target, prune all
      move(1'b0, 32'd0, 100);
      move(1'b0, 32'd0, 100);
      move(1'b0, 32'd127, 100);
      move(1'b0, 32'hffffff80, 100);
      move(1'b0, 32'd128, 100);
      move(1'b0, 32'hffff8000, 100);
      move(1'b0, 32'd32768, 100);
      move(1'b0, 32'h007fffff, 100);
      move(1'b0, 32'hff800000, 100);
      move(1'b0, 32'h7fffffff, 100);
      move(1'b0, 32'h80000000, 100);
      move(1'b1, 32'd5, 100);
      move(1'b1, 32'd7, 100);
      move(1'b1, 32'd5, 100);
      move(1'b1, 32'd7, 100);
      move(1'b1, 32'd5, 100);
      move(1'b1, 32'd9, 100);
      move(1'b1, 32'd9, 0);
      send(dme_pkg::OPER_MOVE, 1'b1, 32'd3, 31'h7fffffff, 31'h7fffffff);
      send(dme_pkg::OPER_PRUNE, 1'b0, 32'd0, cur_pos - 31'd8, 31'd0);
      move(1'b0, 32'd128, 100);
      send(dme_pkg::OPER_PRUNE, 1'b1, $urandom, 31'd0, 31'h7fffffff);
      move(1'b1, 32'd5, 100);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         tx_idle_pct = (ph == 1) ? 73 : (ph == 3 ? 10 : 0);
         rx_stall_pct = (ph == 2) ? 73 : (ph == 3 ? 10 : 0);
         if (ph == 0) hold_off = 1'b1;
         for (int k = 0; k < 75; k++) random_item();
         drain();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
